>>> src/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants for the bilinear pixel sampler.
// ----------------------------------------------------------------------------
package bps_pkg;

	// Frame store geometry
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int CHANNELS = 4;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ADDR_W   = $clog2(MAX_ROWS * MAX_COLS);

	// Fixed-point format: 16.16
	localparam int FRAC_W = 16;
	localparam logic [FRAC_W:0] ONE_FIX = 17'h10000;

	// Channel count register width
	localparam int NCH_W = 3;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_ROWS    = 2'd0,
		CFG_COLS    = 2'd1,
		CFG_BG      = 2'd2,
		CFG_NCH     = 2'd3
	} cfg_idx_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DRAIN,
		ST_BLEND,
		ST_OUT
	} state_t;

	// Control from the sequencer to the blend datapath
	typedef struct packed {
		logic             load;
		logic [NCH_W-1:0] nch;
	} lerp_ctl_t;

endpackage

>>> src/bps_frame_store.sv
// ----------------------------------------------------------------------------
// bps_frame_store
// Pixel word memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bps_frame_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [bps_pkg::ADDR_W-1:0] waddr,
	input  logic [31:0]                wdata,
	input  logic                       re,
	input  logic [bps_pkg::ADDR_W-1:0] raddr,
	output logic [31:0]                rdata
);

	logic [31:0] mem [bps_pkg::MAX_ROWS * bps_pkg::MAX_COLS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/bps_lerp.sv
// ----------------------------------------------------------------------------
// bps_lerp
// Two-step blend of four neighbor words: rows first (registered), then
// columns. Each step keeps the upper bits of a 16-bit fraction product.
// ----------------------------------------------------------------------------
module bps_lerp (
	input  logic                       clk,
	input  bps_pkg::lerp_ctl_t         ctl,
	input  logic [3:0][31:0]           nb,     // 0:r0c0 1:r0c1 2:r1c0 3:r1c1
	input  logic [bps_pkg::FRAC_W-1:0] fi,
	input  logic [bps_pkg::FRAC_W-1:0] fj,
	output logic [3:0][7:0]            chan
);

	logic [bps_pkg::FRAC_W:0]   nfi;
	logic [3:0][24:0]           sa;
	logic [3:0][24:0]           sb;
	logic [3:0][24:0]           so;
	logic [3:0][7:0]            a_s1;
	logic [3:0][7:0]            b_s1;
	logic [bps_pkg::FRAC_W-1:0] fj_s1;
	logic [bps_pkg::FRAC_W:0]   nfj_s1;
	logic [bps_pkg::NCH_W-1:0]  nch_s1;

	assign nfi = bps_pkg::ONE_FIX - {1'b0, fi};

	// row blend, per channel
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sa[k] = 25'(nb[2][8*k +: 8]) * 25'(fi) + 25'(nb[0][8*k +: 8]) * 25'(nfi);
			sb[k] = 25'(nb[3][8*k +: 8]) * 25'(fi) + 25'(nb[1][8*k +: 8]) * 25'(nfi);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int k = 0; k < 4; k++) begin
				a_s1[k] <= sa[k][23:16];
				b_s1[k] <= sb[k][23:16];
			end
			fj_s1  <= fj;
			nfj_s1 <= bps_pkg::ONE_FIX - {1'b0, fj};
			nch_s1 <= ctl.nch;
		end
	end

	// column blend and channel masking
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			so[k]   = 25'(nfj_s1) * 25'(a_s1[k]) + 25'(fj_s1) * 25'(b_s1[k]);
			chan[k] = (bps_pkg::NCH_W'(k) < nch_s1) ? so[k][23:16] : 8'd0;
		end
	end

endmodule

>>> src/bilinear_pixel_sampler_top.sv
// ----------------------------------------------------------------------------
// bilinear_pixel_sampler_top
// Frame store of packed pixels with a bilinear sampler on 16.16 positions.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   in      | sink      | in_valid / in_ready     | op, wr_row, wr_col, pixel_word,
//           |           |                         | pos_row, pos_col
//   out     | source    | out_valid / out_ready   | chan0..chan3
//   cfg     | sink      | cfg_we (no wait)        | cfg_idx, cfg_data
//
// A write item goes straight into the frame store. A sample item passes through
// four reads through the single read port of the frame store, a drain state
// for the registered read data, the row blend and the column blend.
// The result waits in an output register; the next item is taken meanwhile.
// Reset returns control state and configuration to defaults; the frame store is not cleared.
// ----------------------------------------------------------------------------
module bilinear_pixel_sampler_top (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [31:0]        cfg_data,
	// input items
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [5:0]         wr_row,
	input  logic [5:0]         wr_col,
	input  logic [31:0]        pixel_word,
	input  logic signed [31:0] pos_row,
	input  logic signed [31:0] pos_col,
	// result items
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         chan0,
	output logic [7:0]         chan1,
	output logic [7:0]         chan2,
	output logic [7:0]         chan3
);

	localparam int ROW_W  = bps_pkg::ROW_W;
	localparam int COL_W  = bps_pkg::COL_W;
	localparam int ADDR_W = bps_pkg::ADDR_W;

	// configuration registers
	logic [6:0]                rows_q;
	logic [6:0]                cols_q;
	logic [31:0]               bg_q;
	logic [bps_pkg::NCH_W-1:0] nch_q;

	// sequencer
	bps_pkg::state_t           state_q, state_d;
	logic [1:0]                fetch_k_q, fetch_k_d;
	logic                      accept;
	logic                      wr_en;
	logic                      rd_en;
	logic                      load_out;

	// sample position
	logic [31:0]               pos_row_q;
	logic [31:0]               pos_col_q;

	// neighbor addressing
	logic [15:0]               nrows;
	logic [15:0]               ncols;
	logic [16:0]               r_sel;
	logic [16:0]               c_sel;
	logic                      in_img;
	logic [ADDR_W-1:0]         raddr;
	logic [ADDR_W-1:0]         waddr;
	logic [31:0]               rdata;

	// read pipeline
	logic                      rd_vld_s1;
	logic [1:0]                rd_k_s1;
	logic                      rd_img_s1;
	logic [3:0][31:0]          nb_q;

	// blend and output
	bps_pkg::lerp_ctl_t        lctl;
	logic [bps_pkg::NCH_W-1:0] nch_eff;
	logic [3:0][7:0]           chan_w;
	logic                      out_valid_q;
	logic [3:0][7:0]           chan_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd64;
			cols_q <= 7'd64;
			bg_q   <= 32'd0;
			nch_q  <= 3'd3;
		end else if (cfg_we) begin
			case (bps_pkg::cfg_idx_t'(cfg_idx))
				bps_pkg::CFG_ROWS: rows_q <= cfg_data[6:0];
				bps_pkg::CFG_COLS: cols_q <= cfg_data[6:0];
				bps_pkg::CFG_BG:   bg_q   <= cfg_data;
				bps_pkg::CFG_NCH:  nch_q  <= cfg_data[bps_pkg::NCH_W-1:0];
				default: ;
			endcase
		end
	end

	// write path: straight into the store
	assign accept = in_valid && in_ready;
	assign wr_en  = accept && !op
		&& (32'(wr_row) < 32'(bps_pkg::MAX_ROWS))
		&& (32'(wr_col) < 32'(bps_pkg::MAX_COLS));
	assign waddr  = ADDR_W'(ADDR_W'(wr_row[ROW_W-1:0]) * ADDR_W'(bps_pkg::MAX_COLS)
		+ ADDR_W'(wr_col[COL_W-1:0]));

	always_ff @(posedge clk) begin
		if (accept && op) begin
			pos_row_q <= pos_row;
			pos_col_q <= pos_col;
		end
	end

	// image bounds, saturated to the store
	assign nrows = (rows_q < 7'(bps_pkg::MAX_ROWS)) ? 16'(rows_q) : 16'(bps_pkg::MAX_ROWS);
	assign ncols = (cols_q < 7'(bps_pkg::MAX_COLS)) ? 16'(cols_q) : 16'(bps_pkg::MAX_COLS);

	// neighbor k: bit 1 picks the lower row, bit 0 the right column
	assign r_sel  = {pos_row_q[31], pos_row_q[31:16]} + 17'(fetch_k_q[1]);
	assign c_sel  = {pos_col_q[31], pos_col_q[31:16]} + 17'(fetch_k_q[0]);
	assign in_img = !r_sel[16] && !c_sel[16] && (r_sel[15:0] < nrows) && (c_sel[15:0] < ncols);
	assign raddr  = ADDR_W'(ADDR_W'(r_sel[ROW_W-1:0]) * ADDR_W'(bps_pkg::MAX_COLS)
		+ ADDR_W'(c_sel[COL_W-1:0]));

	bps_frame_store u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (pixel_word),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// track reads in flight, substitute background outside the image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_k_s1   <= fetch_k_q;
		rd_img_s1 <= in_img;
		if (rd_vld_s1) begin
			nb_q[rd_k_s1] <= rd_img_s1 ? rdata : bg_q;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bps_pkg::ST_IDLE;
			fetch_k_q <= 2'd0;
		end else begin
			state_q   <= state_d;
			fetch_k_q <= fetch_k_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		fetch_k_d = fetch_k_q;
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		load_out  = 1'b0;
		lctl.load = 1'b0;
		lctl.nch  = nch_eff;
		case (state_q)
			bps_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				fetch_k_d = 2'd0;
				if (in_valid && op) begin
					state_d = bps_pkg::ST_FETCH;
				end
			end
			bps_pkg::ST_FETCH: begin
				rd_en     = 1'b1;
				fetch_k_d = fetch_k_q + 2'd1;
				if (fetch_k_q == 2'd3) begin
					state_d = bps_pkg::ST_DRAIN;
				end
			end
			bps_pkg::ST_DRAIN: begin
				state_d = bps_pkg::ST_BLEND;
			end
			bps_pkg::ST_BLEND: begin
				lctl.load = 1'b1;
				state_d   = bps_pkg::ST_OUT;
			end
			bps_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = bps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bps_pkg::ST_IDLE;
			end
		endcase
	end

	// channel count, limited to four and to the channels built
	always_comb begin
		nch_eff = nch_q;
		if (nch_eff > 3'd4) begin
			nch_eff = 3'd4;
		end
		if (32'(nch_eff) > bps_pkg::CHANNELS) begin
			nch_eff = bps_pkg::NCH_W'(bps_pkg::CHANNELS);
		end
	end

	bps_lerp u_lerp (
		.clk  (clk),
		.ctl  (lctl),
		.nb   (nb_q),
		.fi   (pos_row_q[15:0]),
		.fj   (pos_col_q[15:0]),
		.chan (chan_w)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			chan_q <= chan_w;
		end
	end

	assign out_valid = out_valid_q;
	assign chan0     = chan_q[0];
	assign chan1     = chan_q[1];
	assign chan2     = chan_q[2];
	assign chan3     = chan_q[3];

endmodule

>>> tb/sv/bps_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bps_tb_pkg
// Item opcodes shared by the sampler checker and its test top.
// ----------------------------------------------------------------------------
package bps_tb_pkg;

	// Input item opcode
	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} pixel_op_t;

endpackage

>>> tb/sv/bps_sample_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bps_sample_checker
// Watches the config, input and result channels of the bilinear sampler.
// Keeps a shadow frame store and register set, computes the blended pixel
// for each accepted sample item and compares every result item channel by
// channel against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bps_sample_checker
	import bps_pkg::*;
	import bps_tb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               op,
	input  logic [5:0]         wr_row,
	input  logic [5:0]         wr_col,
	input  logic [31:0]        pixel_word,
	input  logic signed [31:0] pos_row,
	input  logic signed [31:0] pos_col,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [7:0]         chan0,
	input  logic [7:0]         chan1,
	input  logic [7:0]         chan2,
	input  logic [7:0]         chan3,
	output int                 fail_count,
	output int                 pending_results
);

	// Shadow frame store and registers
	logic [31:0] shadow_store [MAX_ROWS*MAX_COLS];
	logic [6:0]  rows_reg;
	logic [6:0]  cols_reg;
	logic [31:0] bg_reg;
	logic [2:0]  nch_reg;

	// Predicted pixels in issue order, channel 0 in the lowest byte
	logic [31:0] blended_q [$];
	int          mismatch_total = 0;

	assign fail_count = mismatch_total;

	task automatic report_mismatch(input string msg);
		if (mismatch_total < 100)
			$display("[%0t] mismatch: %s", $time, msg);
		mismatch_total++;
	endtask

	// Neighbour word, or background when outside the visible image
	function automatic logic [31:0] neighbour(input int r, input int c,
			input int nr, input int nc);
		if (r < 0 || c < 0 || r >= nr || c >= nc)
			return bg_reg;
		return shadow_store[r*MAX_COLS + c];
	endfunction

	// Row blend then column blend, each stage truncated by 16 bits
	function automatic logic [31:0] blend_pixel(input logic [31:0] prow,
			input logic [31:0] pcol);
		int          i0, j0, nr, nc, nch;
		int unsigned fi, fj, nfi, nfj, a, b;
		int unsigned p00, p01, p10, p11;
		logic [31:0] v00, v01, v10, v11, res;
		i0  = $signed(prow) >>> FRAC_W;
		j0  = $signed(pcol) >>> FRAC_W;
		fi  = {16'd0, prow[15:0]};
		fj  = {16'd0, pcol[15:0]};
		nfi = 32'(ONE_FIX) - fi;
		nfj = 32'(ONE_FIX) - fj;
		nr  = (int'(rows_reg) < MAX_ROWS) ? int'(rows_reg) : MAX_ROWS;
		nc  = (int'(cols_reg) < MAX_COLS) ? int'(cols_reg) : MAX_COLS;
		nch = int'(nch_reg);
		if (nch > 4) nch = 4;
		if (nch > CHANNELS) nch = CHANNELS;
		v00 = neighbour(i0,     j0,     nr, nc);
		v01 = neighbour(i0,     j0 + 1, nr, nc);
		v10 = neighbour(i0 + 1, j0,     nr, nc);
		v11 = neighbour(i0 + 1, j0 + 1, nr, nc);
		res = '0;
		for (int k = 0; k < 4; k++) begin
			if (k < nch) begin
				p00 = {24'd0, v00[8*k +: 8]};
				p01 = {24'd0, v01[8*k +: 8]};
				p10 = {24'd0, v10[8*k +: 8]};
				p11 = {24'd0, v11[8*k +: 8]};
				a = (p10*fi + p00*nfi) >> FRAC_W;
				b = (p11*fi + p01*nfi) >> FRAC_W;
				res[8*k +: 8] = 8'((nfj*a + fj*b) >> FRAC_W);
			end
		end
		return res;
	endfunction

	// Track config writes, input items and result items
	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		logic [31:0] got;
		if (!arst_n) begin
			rows_reg = 7'd64;
			cols_reg = 7'd64;
			bg_reg   = '0;
			nch_reg  = 3'd3;
			blended_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_ROWS: rows_reg = cfg_data[6:0];
					CFG_COLS: cols_reg = cfg_data[6:0];
					CFG_BG:   bg_reg   = cfg_data;
					CFG_NCH:  nch_reg  = cfg_data[2:0];
					default:  ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (op == OP_SAMPLE)
					blended_q.push_back(blend_pixel(pos_row, pos_col));
				else
					shadow_store[int'(wr_row)*MAX_COLS + int'(wr_col)] = pixel_word;
			end
			if (out_valid && out_ready) begin
				got = {chan3, chan2, chan1, chan0};
				if (blended_q.size() == 0) begin
					report_mismatch($sformatf("result item %08h with no sample pending", got));
				end else begin
					want = blended_q.pop_front();
					for (int k = 0; k < 4; k++)
						if (got[8*k +: 8] !== want[8*k +: 8])
							report_mismatch($sformatf("chan%0d got %02h expected %02h",
								k, got[8*k +: 8], want[8*k +: 8]));
				end
			end
		end
		pending_results = blended_q.size();
	end

endmodule

>>> tb/sv/bilinear_pixel_sampler_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_pixel_sampler_top_test
// Stimulus and verdict for the bilinear pixel sampler.
// A directed opening hits image corners, fraction extremes and far positions,
// then several register settings (zero size, oversize, channel counts 0..2, 4, 5, 7)
// each get a random mix of pixel writes and sample items. Every in-image
// neighbour is written before it is sampled. Sender runs in random bursts,
// receiver stalls on its own pattern; bps_sample_checker does the compare.
// ----------------------------------------------------------------------------
module bilinear_pixel_sampler_top_test;
	import bps_pkg::*;
	import bps_tb_pkg::*;

	logic               clk;
	logic               arst_n     = 1'b0;
	logic               cfg_we     = 1'b0;
	logic [1:0]         cfg_idx    = CFG_ROWS;
	logic [31:0]        cfg_data   = '0;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	logic               op         = OP_WRITE;
	logic [5:0]         wr_row     = '0;
	logic [5:0]         wr_col     = '0;
	logic [31:0]        pixel_word = '0;
	logic signed [31:0] pos_row    = '0;
	logic signed [31:0] pos_col    = '0;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	logic [7:0]         chan0, chan1, chan2, chan3;
	int                 fail_count;
	int                 pending_results;

	// Stimulus-side view of the image, to avoid sampling unwritten pixels
	bit written [MAX_ROWS*MAX_COLS];
	int img_rows = MAX_ROWS;
	int img_cols = MAX_COLS;
	int burst_left = 0;
	int items_sent = 0;
	logic in_take = 1'b0;

	bilinear_pixel_sampler_top dut (.*);
	bps_sample_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Registered accept flag, read back at the falling edge
	always @(posedge clk)
		in_take <= in_valid && in_ready;

	// Receiver: switches between always-ready, coin flip and long stalls
	int rx_mode = 0;
	int rx_mode_left = 0;
	int rx_stall_left = 0;
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mode_left = $urandom_range(32, 256);
		end
		rx_mode_left--;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: begin
				if (rx_stall_left == 0) begin
					out_ready <= 1'b1;
					rx_stall_left = $urandom_range(1, 16);
				end else begin
					out_ready <= 1'b0;
					rx_stall_left--;
				end
			end
		endcase
	end

	// Present one item and hold it until taken; gaps between bursts
	task automatic push_item(input pixel_op_t kind, input logic [5:0] r,
			input logic [5:0] c, input logic [31:0] px,
			input logic [31:0] pr, input logic [31:0] pc);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid   <= 1'b1;
		op         <= kind;
		wr_row     <= r;
		wr_col     <= c;
		pixel_word <= px;
		pos_row    <= pr;
		pos_col    <= pc;
		do @(negedge clk); while (!in_take);
		burst_left--;
		items_sent++;
	endtask

	task automatic write_pixel(input logic [5:0] r, input logic [5:0] c,
			input logic [31:0] px);
		push_item(OP_WRITE, r, c, px, $urandom, $urandom);
		written[int'(r)*MAX_COLS + int'(c)] = 1'b1;
	endtask

	// Fill any unwritten in-image neighbour first, then sample
	task automatic sample_at(input logic [31:0] pr, input logic [31:0] pc);
		int i0, j0, r, c;
		i0 = $signed(pr) >>> FRAC_W;
		j0 = $signed(pc) >>> FRAC_W;
		for (int dr = 0; dr < 2; dr++)
			for (int dc = 0; dc < 2; dc++) begin
				r = i0 + dr;
				c = j0 + dc;
				if (r >= 0 && c >= 0 && r < img_rows && c < img_cols
						&& !written[r*MAX_COLS + c])
					write_pixel(6'(r), 6'(c), $urandom);
			end
		push_item(OP_SAMPLE, 6'($urandom), 6'($urandom), $urandom, pr, pc);
	endtask

	// Drop valid and wait for the block to drain
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_results != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_regs(input logic [6:0] rows, input logic [6:0] cols,
			input logic [31:0] bg, input logic [2:0] nch);
		settle();
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_ROWS;
		cfg_data <= {25'd0, rows};
		@(negedge clk);
		cfg_idx  <= CFG_COLS;
		cfg_data <= {25'd0, cols};
		@(negedge clk);
		cfg_idx  <= CFG_BG;
		cfg_data <= bg;
		@(negedge clk);
		cfg_idx  <= CFG_NCH;
		cfg_data <= {29'd0, nch};
		@(negedge clk);
		cfg_we   <= 1'b0;
		img_rows = (int'(rows) < MAX_ROWS) ? int'(rows) : MAX_ROWS;
		img_cols = (int'(cols) < MAX_COLS) ? int'(cols) : MAX_COLS;
	endtask

	// Position near the image edge range, with extreme fractions favored
	function automatic logic [31:0] near_pos(input int extent);
		int ip;
		logic [15:0] fr;
		ip = int'($urandom_range(0, extent + 3)) - 2;
		case ($urandom_range(0, 3))
			0:       fr = 16'h0000;
			1:       fr = 16'hffff;
			default: fr = 16'($urandom);
		endcase
		return {ip[15:0], fr};
	endfunction

	// Random mix: mostly near-image samples, some stray writes, some far samples
	task automatic random_phase(input int count);
		int stop, pick;
		stop = items_sent + count;
		while (items_sent < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				sample_at(near_pos(img_rows), near_pos(img_cols));
			else if (pick < 85)
				write_pixel(6'($urandom), 6'($urandom), $urandom);
			else
				sample_at($urandom, $urandom);
		end
	endtask

	// Run limit
	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: corner blends, fraction extremes, bottom edge, far positions
		write_pixel(6'd0, 6'd0, 32'hffffffff);
		write_pixel(6'd0, 6'd1, 32'h00000000);
		write_pixel(6'd1, 6'd0, 32'h00000000);
		write_pixel(6'd1, 6'd1, 32'hffffffff);
		sample_at(32'h00000000, 32'h00000000);
		sample_at(32'h0000ffff, 32'h0000ffff);
		sample_at(32'h00008000, 32'h00008000);
		sample_at(32'h0000ffff, 32'h00000000);
		write_pixel(6'd63, 6'd63, 32'h5a5a5a5a);
		sample_at(32'h003f0000, 32'h003f0000);
		sample_at(32'h003effff, 32'h003effff);
		sample_at(32'hffffffff, 32'hffff8000);
		sample_at(32'h80000000, 32'h7fffffff);
		sample_at(32'h7fffffff, 32'h80000000);
		write_pixel(6'd63, 6'd0, 32'h00000000);

		// Register settings: full image, single pixel, zero size, oversize,
		// channel counts zero, one, two, four, five, seven and a random one to four
		write_regs(7'd64, 7'd64, $urandom, 3'd4);
		random_phase(125);
		write_regs(7'd1, 7'd1, 32'hffffffff, 3'd4);
		random_phase(125);
		write_regs(7'd0, 7'd64, $urandom, 3'd2);
		random_phase(125);
		write_regs(7'd127, 7'd100, $urandom, 3'd7);
		random_phase(125);
		write_regs(7'd64, 7'd0, $urandom, 3'd0);
		random_phase(125);
		write_regs(7'd2, 7'd3, 32'h00000000, 3'd1);
		random_phase(125);
		write_regs(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)), $urandom,
			3'($urandom_range(1, 4)));
		random_phase(125);
		write_regs(7'd65, 7'd64, $urandom, 3'd5);
		random_phase(125);

		settle();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
